// ===== rtl/rmbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmbm_pkg
// Shared types and constants for the running-mean background / motion block.
// ----------------------------------------------------------------------------
package rmbm_pkg;

    localparam int MAX_PIXELS_DEF = 307200;
    localparam int COUNT_MAX_DEF  = 65535;

    // quotient bits of the mean, one divider stage each
    localparam int DIV_BITS = 16;
    localparam int NUM_W    = 33;
    localparam int DEN_W    = 17;

    localparam int THR_W       = 10;
    localparam int THR_RESET   = 20;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DRAWING   = 1'd1;

    localparam logic CMD_PIXEL   = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    localparam logic [7:0] CH_FULL = 8'd255;

    // item data that rides alongside the arithmetic
    typedef struct packed {
        logic [2:0][7:0] raw;
        logic            first;
        logic            draw;
    } rmbm_side_t;

endpackage

// ===== rtl/rmbm_mean_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmbm_mean_pipe
// Pipelined cumulative mean: old*n + raw*256, then a one-bit-per-stage
// restoring divide by n+1 for all three channels.
// ----------------------------------------------------------------------------
module rmbm_mean_pipe #(
    parameter int POS_W = 19
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [POS_W-1:0]          in_pos,
    input  logic [15:0]               in_n,
    input  logic [2:0][15:0]          in_old,
    input  rmbm_pkg::rmbm_side_t      in_side,
    input  logic [POS_W-1:0]          chk_pos,
    output logic                      chk_hit,
    output logic                      out_valid,
    output logic [POS_W-1:0]          out_pos,
    output logic [2:0][15:0]          out_mean,
    output rmbm_pkg::rmbm_side_t      out_side
);
    import rmbm_pkg::*;

    // multiply stage
    logic                    m_valid_reg;
    logic [POS_W-1:0]        m_pos_reg;
    logic [2:0][31:0]        m_prod_reg;
    logic [DEN_W-1:0]        m_den_reg;
    rmbm_side_t              m_side_reg;

    // stage 0 holds the numerator, stages 1..DIV_BITS the divide steps
    logic                    vld_reg  [0:DIV_BITS];
    logic [POS_W-1:0]        pos_reg  [0:DIV_BITS];
    logic [2:0][NUM_W-1:0]   rem_reg  [0:DIV_BITS];
    logic [2:0][15:0]        q_reg    [0:DIV_BITS];
    logic [DEN_W-1:0]        den_reg  [0:DIV_BITS];
    rmbm_side_t              side_reg [0:DIV_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            for (int j = 0; j <= DIV_BITS; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            m_valid_reg <= in_valid;
            vld_reg[0]  <= m_valid_reg;
            for (int j = 1; j <= DIV_BITS; j++)
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_pos_reg  <= in_pos;
            m_den_reg  <= DEN_W'(in_n) + DEN_W'(1);
            m_side_reg <= in_side;
            for (int c = 0; c < 3; c++)
            begin
                m_prod_reg[c] <= in_old[c] * in_n;
            end
            pos_reg[0]  <= m_pos_reg;
            den_reg[0]  <= m_den_reg;
            side_reg[0] <= m_side_reg;
            q_reg[0]    <= '0;
            for (int c = 0; c < 3; c++)
            begin
                rem_reg[0][c] <= NUM_W'(m_prod_reg[c])
                                 + NUM_W'({m_side_reg.raw[c], 8'h00});
            end
        end
    end

    for (genvar j = 1; j <= DIV_BITS; j++)
    begin : g_div
        logic [2:0][NUM_W-1:0] rem_next;
        logic [2:0][15:0]      q_next;

        always_comb
        begin
            logic [NUM_W-1:0] sub;
            sub = NUM_W'(den_reg[j-1]) << (DIV_BITS - j);
            for (int c = 0; c < 3; c++)
            begin
                rem_next[c] = rem_reg[j-1][c];
                q_next[c]   = q_reg[j-1][c];
                if (rem_reg[j-1][c] >= sub)
                begin
                    rem_next[c]            = rem_reg[j-1][c] - sub;
                    q_next[c][DIV_BITS-j]  = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                q_reg[j]    <= q_next;
                den_reg[j]  <= den_reg[j-1];
                pos_reg[j]  <= pos_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // any in-flight item on the same position whose result is not yet stored
    always_comb
    begin
        chk_hit = m_valid_reg && (m_pos_reg == chk_pos);
        for (int j = 0; j <= DIV_BITS; j++)
        begin
            if (vld_reg[j] && (pos_reg[j] == chk_pos))
            begin
                chk_hit = 1'b1;
            end
        end
    end

    assign out_valid = vld_reg[DIV_BITS];
    assign out_pos   = pos_reg[DIV_BITS];
    assign out_mean  = q_reg[DIV_BITS];
    assign out_side  = side_reg[DIV_BITS];

endmodule

// ===== rtl/running_mean_background_motion_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_mean_background_motion_top
// Per-pixel cumulative-mean background in 8.8 fixed point with a movement
// image update for each pixel request.
//
//   channel  dir  signals                         contents
//   s_       in   tvalid tready tdata tuser tlast pixel request / restart
//   m_       out  tvalid tready tdata             background and movement
//   cfg_     in   valid ready addr data           register writes
//
// one pixel per cycle unless an m_ stall or a position wait holds it, through
// store read, multiply, numerator, sixteen divide stages and output register
// a pixel waits at the input while an earlier pixel on the same position is
// still in flight, which only happens on frames shorter than 20 pixels or
// soon after a restart
// restart requests give no result
// an m_ stall freezes the whole pipeline; the background store has no reset
// ----------------------------------------------------------------------------
module running_mean_background_motion_top #(
    parameter int MAX_PIXELS = rmbm_pkg::MAX_PIXELS_DEF,
    parameter int COUNT_MAX  = rmbm_pkg::COUNT_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // red, green, blue
    input  logic                              s_tuser,   // cmd
    input  logic                              s_tlast,   // end_of_frame
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // bg_red, bg_green, bg_blue, move_write, move_red, move_green,
    // move_blue, move_alpha, zero fill
    output logic [63:0]                       m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rmbm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [rmbm_pkg::THR_W-1:0]        cfg_data
);
    import rmbm_pkg::*;

    localparam int POS_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    logic                   en;
    logic                   hazard;
    logic                   s_acc;
    logic                   pix_acc;

    logic signed [THR_W-1:0] threshold_reg;
    logic                   drawing_reg;
    logic [15:0]            frame_count_reg;
    logic                   first_frame_reg;
    logic [POS_W-1:0]       position_reg;

    logic [2:0][15:0]       bg_mem [MAX_PIXELS];

    logic                   a_valid_reg;
    logic [POS_W-1:0]       a_pos_reg;
    logic [15:0]            a_n_reg;
    rmbm_side_t             a_side_reg;
    logic [2:0][15:0]       a_old_reg;

    logic                   p_valid;
    logic [POS_W-1:0]       p_pos;
    logic [2:0][15:0]       p_mean;
    rmbm_side_t             p_side;
    logic                   p_hit;

    logic [2:0][15:0]       bg_new;
    logic                   all_moved;
    logic [63:0]            out_next;

    logic                   m_valid_reg;
    logic [63:0]            m_data_reg;

    assign en        = !m_valid_reg || m_tready;
    assign hazard    = p_hit || (a_valid_reg && (a_pos_reg == position_reg));
    assign s_tready  = en && !hazard;
    assign s_acc     = s_tvalid && s_tready;
    assign pix_acc   = s_acc && (s_tuser == CMD_PIXEL);
    assign cfg_ready = 1'b1;

    // configuration and frame tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THR_W'(THR_RESET);
            drawing_reg     <= 1'b0;
            frame_count_reg <= 16'd1;
            first_frame_reg <= 1'b1;
            position_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_addr)
                    REG_THRESHOLD: threshold_reg <= cfg_data;
                    REG_DRAWING:
                    begin
                        // a restart in the same cycle clears drawing instead
                        if (!(s_acc && (s_tuser == CMD_RESTART)))
                        begin
                            drawing_reg <= cfg_data[0];
                        end
                    end
                    default:       ;
                endcase
            end
            if (s_acc && (s_tuser == CMD_RESTART))
            begin
                frame_count_reg <= 16'd1;
                first_frame_reg <= 1'b1;
                position_reg    <= '0;
                drawing_reg     <= 1'b0;
            end
            else if (pix_acc)
            begin
                if (s_tlast)
                begin
                    first_frame_reg <= 1'b0;
                    position_reg    <= '0;
                    if (frame_count_reg < 16'(COUNT_MAX))
                    begin
                        frame_count_reg <= frame_count_reg + 16'd1;
                    end
                end
                else if (position_reg == POS_W'(MAX_PIXELS - 1))
                begin
                    position_reg <= '0;
                end
                else
                begin
                    position_reg <= position_reg + POS_W'(1);
                end
            end
        end
    end

    // entry stage: capture the pixel and read its background
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= pix_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_pos_reg        <= position_reg;
            a_n_reg          <= frame_count_reg;
            a_side_reg.raw   <= s_tdata;
            a_side_reg.first <= first_frame_reg;
            a_side_reg.draw  <= drawing_reg;
            a_old_reg        <= bg_mem[position_reg];
        end
    end

    rmbm_mean_pipe #(
        .POS_W (POS_W)
    ) u_mean (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a_valid_reg),
        .in_pos    (a_pos_reg),
        .in_n      (a_n_reg),
        .in_old    (a_old_reg),
        .in_side   (a_side_reg),
        .chk_pos   (position_reg),
        .chk_hit   (p_hit),
        .out_valid (p_valid),
        .out_pos   (p_pos),
        .out_mean  (p_mean),
        .out_side  (p_side)
    );

    // write-back and movement test
    always_comb
    begin
        logic signed [18:0] dev;
        logic signed [18:0] lim;
        lim       = {threshold_reg[THR_W-1], threshold_reg, 8'h00};
        all_moved = 1'b1;
        for (int c = 0; c < 3; c++)
        begin
            bg_new[c] = p_side.first ? {p_side.raw[c], 8'h00} : p_mean[c];
            dev = $signed({3'b000, p_side.raw[c], 8'h00}) - $signed({3'b000, bg_new[c]});
            if (!((dev > lim) || (dev < -lim)))
            begin
                all_moved = 1'b0;
            end
        end
        out_next        = '0;
        out_next[7:0]   = bg_new[0][15:8];
        out_next[15:8]  = bg_new[1][15:8];
        out_next[23:16] = bg_new[2][15:8];
        if (!p_side.draw)
        begin
            out_next[24]    = 1'b1;
            out_next[32:25] = CH_FULL;
            out_next[40:33] = CH_FULL;
            out_next[48:41] = CH_FULL;
        end
        else if (all_moved)
        begin
            out_next[24]    = 1'b1;
            out_next[32:25] = p_side.raw[0];
            out_next[40:33] = p_side.raw[1];
            out_next[48:41] = p_side.raw[2];
            out_next[56:49] = CH_FULL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && p_valid)
        begin
            bg_mem[p_pos] <= bg_new;
        end
        if (en)
        begin
            m_data_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= p_valid;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/rmbm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmbm_checker
// Port-level checks on the result stream of the background / motion block.
// ----------------------------------------------------------------------------
module rmbm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no write means an all-zero movement pixel
    a_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[24] |-> (m_tdata[56:25] == 32'd0))
        else $error("movement fields set without write");

    // a transparent write is a clear to white
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[24] && (m_tdata[56:49] == 8'd0)
        |-> (m_tdata[48:25] == 24'hFFFFFF))
        else $error("clear is not white");

    // alpha is fully transparent or fully opaque, padding stays zero
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[56:49] == 8'd0) || (m_tdata[56:49] == 8'd255))
                     && (m_tdata[63:57] == 7'd0))
        else $error("bad alpha or padding");

endmodule

bind running_mean_background_motion_top rmbm_checker u_rmbm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the running-mean background / motion block.
// Pixel frames with random colours run through the block under several
// threshold and drawing settings. A behavioural background model predicts
// every result, and each result is checked field by field against it.
// Both stream sides idle at random, apart from every third random phase.
// ----------------------------------------------------------------------------
module tb_top;
    import rmbm_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int IDLE_MAX    = 17;
    localparam int DRAIN       = 30;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASES      = 8;
    localparam int PHASE_PIX   = 125;

    typedef struct {
        logic       cmd;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       eof;
    } pixel_req_t;

    typedef struct packed {
        logic [6:0] pad;
        logic [7:0] mv_alpha;
        logic [7:0] mv_blue;
        logic [7:0] mv_green;
        logic [7:0] mv_red;
        logic       mv_write;
        logic [7:0] bg_blue;
        logic [7:0] bg_green;
        logic [7:0] bg_red;
    } bg_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [THR_W-1:0]      cfg_data = '0;

    running_mean_background_motion_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // stimulus and expectations
    pixel_req_t pending_pixels[$];
    bg_result_t bg_expected[$];
    int         errors = 0;
    int         pixels_sent = 0;
    int         restarts_sent = 0;
    int         results_seen = 0;
    int         idle_max = IDLE_MAX;
    int         stall_cycles = 0;

    // background model state
    logic [2:0][15:0]  bg_store [int];
    logic [15:0]       frame_cnt = 16'd1;
    logic              learning = 1'b1;
    int                pix_pos = 0;
    logic signed [THR_W-1:0] thr_model = THR_W'(THR_RESET);
    logic              draw_model = 1'b0;

    // generator-side view of how much of the store holds data
    int written_len = 0;

    function automatic bit moved(logic [7:0] raw, logic [15:0] bg, logic signed [THR_W-1:0] thr);
        int d;
        int t;
        d = int'(raw) * 256 - int'(bg);
        t = int'(thr) * 256;
        return (d > t) || (d < -t);
    endfunction

    task automatic predict_background(pixel_req_t p);
        bg_result_t r;
        logic [7:0] raw [3];
        longint num;
        longint q;
        bit all_moved;
        all_moved = 1'b1;
        if (p.cmd == CMD_RESTART)
        begin
            frame_cnt  = 16'd1;
            learning   = 1'b1;
            pix_pos    = 0;
            draw_model = 1'b0;
            return;
        end
        raw[0] = p.red;
        raw[1] = p.green;
        raw[2] = p.blue;
        if (!bg_store.exists(pix_pos))
            bg_store[pix_pos] = '0;
        for (int c = 0; c < 3; c++)
        begin
            if (learning)
                bg_store[pix_pos][c] = {raw[c], 8'd0};
            else
            begin
                num = longint'(bg_store[pix_pos][c]) * longint'(frame_cnt)
                      + (longint'(raw[c]) << 8);
                q = num / (longint'(frame_cnt) + 1);
                bg_store[pix_pos][c] = (q > 65535) ? 16'hFFFF : q[15:0];
            end
            if (!moved(raw[c], bg_store[pix_pos][c], thr_model))
                all_moved = 1'b0;
        end
        r = '0;
        r.bg_red   = bg_store[pix_pos][0][15:8];
        r.bg_green = bg_store[pix_pos][1][15:8];
        r.bg_blue  = bg_store[pix_pos][2][15:8];
        if (!draw_model)
        begin
            r.mv_write = 1'b1;
            r.mv_red   = CH_FULL;
            r.mv_green = CH_FULL;
            r.mv_blue  = CH_FULL;
        end
        else if (all_moved)
        begin
            r.mv_write = 1'b1;
            r.mv_red   = p.red;
            r.mv_green = p.green;
            r.mv_blue  = p.blue;
            r.mv_alpha = CH_FULL;
        end
        bg_expected.insert(bg_expected.size(), r);
        if (p.eof)
        begin
            learning = 1'b0;
            pix_pos  = 0;
            if (frame_cnt < 16'hFFFF)
                frame_cnt = frame_cnt + 16'd1;
        end
        else
            pix_pos = (pix_pos + 1 >= MAX_PIXELS_DEF) ? 0 : pix_pos + 1;
    endtask

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    // monitor: requests, results, watchdog
    logic s_fire = 1'b0;
    logic m_fire = 1'b0;
    always @(posedge clk)
    begin
        pixel_req_t p;
        bg_result_t a;
        bg_result_t e;
        s_fire <= s_tvalid && s_tready;
        m_fire <= m_tvalid && m_tready;
        if (s_tvalid && s_tready)
        begin
            p.cmd   = s_tuser;
            p.red   = s_tdata[7:0];
            p.green = s_tdata[15:8];
            p.blue  = s_tdata[23:16];
            p.eof   = s_tlast;
            predict_background(p);
        end
        if (m_tvalid && m_tready)
        begin
            a = m_tdata;
            results_seen++;
            if (bg_expected.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, actual %h", $time, m_tdata);
            end
            else
            begin
                e = bg_expected.pop_front();
                check_field("bg_red", e.bg_red, a.bg_red);
                check_field("bg_green", e.bg_green, a.bg_green);
                check_field("bg_blue", e.bg_blue, a.bg_blue);
                check_field("move_write", e.mv_write, a.mv_write);
                check_field("move_red", e.mv_red, a.mv_red);
                check_field("move_green", e.mv_green, a.mv_green);
                check_field("move_blue", e.mv_blue, a.mv_blue);
                check_field("move_alpha", e.mv_alpha, a.mv_alpha);
                check_field("zero fill", 0, a.pad);
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (rst_n)
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // request driver
    int s_gap = 0;
    always @(negedge clk)
    begin
        pixel_req_t p;
        if (rst_n && !(s_tvalid && !s_fire))
        begin
            if (s_gap > 0)
            begin
                s_tvalid <= 1'b0;
                s_gap = s_gap - 1;
            end
            else if (pending_pixels.size() > 0)
            begin
                p = pending_pixels.pop_front();
                s_tuser  <= p.cmd;
                s_tdata  <= {p.blue, p.green, p.red};
                s_tlast  <= p.eof;
                s_tvalid <= 1'b1;
                s_gap = $urandom_range(0, idle_max);
                if (p.cmd == CMD_RESTART)
                    restarts_sent++;
                else
                    pixels_sent++;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result receiver
    int m_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (m_fire)
                m_gap = $urandom_range(0, idle_max);
            if (m_gap > 0)
            begin
                m_tready <= 1'b0;
                m_gap = m_gap - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [THR_W-1:0] data);
        @(negedge clk);
        cfg_addr  <= addr;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (addr == REG_THRESHOLD)
            thr_model = data;
        else
            draw_model = data[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (pending_pixels.size() != 0 || s_tvalid || bg_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic queue_item(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b, logic eof);
        pixel_req_t p;
        p.cmd   = cmd;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        p.eof   = eof;
        pending_pixels.insert(pending_pixels.size(), p);
    endtask

    // one frame of random pixels; a learning frame extends the written area
    task automatic queue_frame(int len, bit first, bit cut);
        for (int i = 0; i < len; i++)
            queue_item(CMD_PIXEL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), !cut && (i == len - 1));
        if (first && len > written_len)
            written_len = len;
    endtask

    initial
    begin
        int n;
        int len;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, restart in mid frame, short frames, threshold limits
        write_reg(REG_THRESHOLD, 10'sd0);
        write_reg(REG_DRAWING, 10'd1);
        queue_item(CMD_PIXEL, 8'd0, 8'd255, 8'd0, 1'b0);
        queue_item(CMD_PIXEL, 8'd255, 8'd0, 8'd255, 1'b0);
        queue_item(CMD_PIXEL, 8'd128, 8'd1, 8'd254, 1'b1);
        queue_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0);
        queue_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0);
        queue_item(CMD_PIXEL, 8'd128, 8'd1, 8'd254, 1'b1);
        queue_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0);
        queue_item(CMD_RESTART, 8'd255, 8'd255, 8'd255, 1'b1);
        queue_item(CMD_PIXEL, 8'd10, 8'd20, 8'd30, 1'b1);
        queue_item(CMD_PIXEL, 8'd250, 8'd240, 8'd230, 1'b1);
        queue_item(CMD_PIXEL, 8'd10, 8'd20, 8'd30, 1'b1);
        written_len = 3;
        wait_idle();
        write_reg(REG_THRESHOLD, -10'sd256);
        write_reg(REG_DRAWING, 10'd1);
        queue_item(CMD_PIXEL, 8'd10, 8'd20, 8'd30, 1'b1);
        queue_item(CMD_PIXEL, 8'd0, 8'd255, 8'd7, 1'b1);
        wait_idle();
        write_reg(REG_THRESHOLD, 10'sd256);
        queue_item(CMD_PIXEL, 8'd255, 8'd0, 8'd255, 1'b1);
        wait_idle();
        write_reg(REG_THRESHOLD, -10'sd1);
        queue_item(CMD_PIXEL, 8'd1, 8'd2, 8'd3, 1'b1);
        wait_idle();
        write_reg(REG_THRESHOLD, 10'sd255);
        queue_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b1);
        wait_idle();

        // random phases: a random mix of restarts, learning frames and averaging frames
        for (int ph = 0; ph < PHASES; ph++)
        begin
            idle_max = (ph % 3 == 2) ? 0 : IDLE_MAX;
            if (ph == PHASES - 1)
                write_reg(REG_THRESHOLD, 10'sd256);
            else if (ph == PHASES - 2)
                write_reg(REG_THRESHOLD, -10'sd256);
            else
                write_reg(REG_THRESHOLD, THR_W'($urandom_range(0, 512) - 256));
            write_reg(REG_DRAWING, THR_W'($urandom_range(0, 1)));
            n = 0;
            while (n < PHASE_PIX)
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        // restart, then a learning frame, sometimes a long one
                        queue_item(CMD_RESTART, 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                        len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(1, 24);
                        queue_frame(len, 1'b1, $urandom_range(0, 5) == 0);
                    end
                    1:
                    begin
                        // broken frame, cut short by a restart, then a learning frame
                        len = $urandom_range(1, written_len);
                        queue_frame(len, 1'b0, 1'b1);
                        queue_item(CMD_RESTART, 8'd0, 8'd0, 8'd0, 1'b0);
                        len = $urandom_range(1, 24);
                        queue_frame(len, 1'b1, 1'b0);
                    end
                    default:
                    begin
                        // averaging frame, never past the written area
                        len = ($urandom_range(0, 1) == 0) ? written_len
                                                          : $urandom_range(1, written_len);
                        queue_frame(len, 1'b0, 1'b0);
                    end
                endcase
                n = n + len;
            end
            // the sender holds back until every result of the phase is in
            wait_idle();
        end

        $display("%0d pixel and %0d restart requests over %0d register settings,",
                 pixels_sent, restarts_sent, PHASES + 5);
        $display("%0d results checked, %0d mismatches", results_seen, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rmbm_pkg.sv
rtl/rmbm_mean_pipe.sv
rtl/running_mean_background_motion_top.sv
rtl/rmbm_checker.sv
verif/tb_top.sv
